// ----- rtl/core/mam_pkg.sv -----
// Shared types and constants for the modular arithmetic unit.
package mam_pkg;

  localparam logic [31:0] MOD_RESET = 32'd998244353;
  localparam int unsigned OPND_W    = 32;
  localparam int unsigned CMD_W     = 3;
  localparam int unsigned IN_DATA_W = 72;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_POW = 3'd4
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RED_A,
    S_RED_B,
    S_ARITH,
    S_CORR,
    S_POW_CHK,
    S_POW_ACC,
    S_POW_SQ,
    S_MUL_FIN,
    S_DONE
  } state_t;

  // request to the serial multiplier
  typedef struct packed {
    logic start;
    logic wide;   // scan all 32 multiplier bits, else MOD_BITS bits
  } mul_req_t;

endpackage

// ----- rtl/core/mam_mulmod.sv -----
// Bit-serial modular multiplier: result = (x * y) mod m, each multiplier bit in a doubling phase and an add phase.
module mam_mulmod #(
  parameter int unsigned MOD_BITS = 31
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  mam_pkg::mul_req_t       req,
  input  logic [MOD_BITS-1:0]     m,
  input  logic [MOD_BITS-1:0]     x,
  input  logic [mam_pkg::OPND_W-1:0] y,
  output logic                    busy,
  output logic                    done,
  output logic [MOD_BITS-1:0]     result
);

  localparam int unsigned YW      = mam_pkg::OPND_W;
  localparam int unsigned CNT_W   = $clog2(YW + 1);
  localparam int unsigned Y_SHIFT = YW - MOD_BITS;

  logic [MOD_BITS-1:0] acc_r, acc_nxt;
  logic [MOD_BITS-1:0] x_r;
  logic [YW-1:0]       y_r, y_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                phase_r, phase_nxt;
  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;

  logic [MOD_BITS:0]   sum;
  logic [MOD_BITS+1:0] diff;
  logic [MOD_BITS-1:0] red;

  // phase 0 doubles the accumulator, phase 1 adds x when the multiplier bit is set
  always_comb begin
    if (!phase_r) begin
      sum = {acc_r, 1'b0};
    end else if (y_r[YW-1]) begin
      sum = {1'b0, acc_r} + {1'b0, x_r};
    end else begin
      sum = {1'b0, acc_r};
    end
    diff = {1'b0, sum} - {2'b00, m};
    red  = diff[MOD_BITS+1] ? sum[MOD_BITS-1:0] : diff[MOD_BITS-1:0];
  end

  always_comb begin
    acc_nxt   = acc_r;
    y_nxt     = y_r;
    cnt_nxt   = cnt_r;
    phase_nxt = phase_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (!busy_r) begin
      if (req.start) begin
        acc_nxt   = '0;
        y_nxt     = req.wide ? y : (y << Y_SHIFT);
        cnt_nxt   = req.wide ? CNT_W'(YW) : CNT_W'(MOD_BITS);
        phase_nxt = 1'b0;
        busy_nxt  = 1'b1;
      end
    end else begin
      acc_nxt   = red;
      phase_nxt = ~phase_r;
      if (phase_r) begin
        y_nxt   = {y_r[YW-2:0], 1'b0};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      phase_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      busy_r  <= busy_nxt;
      done_r  <= done_nxt;
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    y_r   <= y_nxt;
    if (!busy_r && req.start) begin
      x_r <= x;
    end
  end

  assign busy   = busy_r;
  assign done   = done_r;
  assign result = acc_r;

endmodule

// ----- rtl/core/modular_arithmetic_unit_top.sv -----
// Top level of the modular arithmetic unit: request sequencer, modulus register, output register.
//
// Add, subtract, multiply, divide and power modulo a modulus held in the cfg register.
// All multiplications, operand reduction included, run on one bit-serial modular multiplier
// that handles each multiplier bit in a doubling phase and an add phase, plus an issue step
// and a hand-off step per product. Both operands are first reduced by that multiplier
// (32 bits each). Add and subtract then finish in the ARITH and CORR states, multiply in
// ARITH and MUL_FIN. Power and divide run square-and-multiply over the exponent: up to
// 2*MOD_BITS-1 multiplications and a check step per exponent bit, plus one final multiply
// for divide. One request is processed at a time; a new request is taken while the previous
// result waits in the output register. A modulus below 2 returns 0.
module modular_arithmetic_unit_top #(
  parameter int unsigned MOD_BITS = 31
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [MOD_BITS-1:0]             cfg_wdata,  // modulus
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [mam_pkg::IN_DATA_W-1:0]   in_tdata,   // cmd[2:0], operand_a[34:3], operand_b[66:35]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [((MOD_BITS+7)/8)*8-1:0]   out_tdata   // result[MOD_BITS-1:0]
);

  localparam int unsigned OUT_W = ((MOD_BITS + 7) / 8) * 8;
  localparam int unsigned OW    = mam_pkg::OPND_W;
  localparam int unsigned CW    = mam_pkg::CMD_W;

  mam_pkg::state_t state_r, state_nxt;

  logic [MOD_BITS-1:0] mod_r;
  logic [CW-1:0]       cmd_r;
  logic [OW-1:0]       a_raw_r, b_raw_r;
  logic [MOD_BITS-1:0] a_r, b_r, acc_r, sq_r, e_r, res_r;
  logic [MOD_BITS:0]   t_r;
  logic [MOD_BITS-1:0] out_data_r;
  logic                out_valid_r;
  logic                issued_r;

  mam_pkg::mul_req_t   mreq;
  logic [MOD_BITS-1:0] mx;
  logic [OW-1:0]       my;
  logic                m_busy, m_done;
  logic [MOD_BITS-1:0] m_res;

  logic                accept, mod_small, mul_state, out_load;
  logic [MOD_BITS+1:0] corr_diff;
  logic [MOD_BITS:0]   corr_sum;

  assign accept    = in_tvalid && in_tready;
  assign mod_small = (mod_r < MOD_BITS'(2));
  assign out_load  = (state_r == mam_pkg::S_DONE) && (!out_valid_r || out_tready);
  assign mul_state = (state_r == mam_pkg::S_RED_A) || (state_r == mam_pkg::S_RED_B) ||
                     (state_r == mam_pkg::S_POW_ACC) || (state_r == mam_pkg::S_POW_SQ) ||
                     (state_r == mam_pkg::S_MUL_FIN);

  // add: t = a + b, subtract from m when t >= m; sub: t = a - b, add m on borrow
  assign corr_diff = {1'b0, t_r} - {2'b00, mod_r};
  assign corr_sum  = t_r + {1'b0, mod_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mam_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = mod_small ? mam_pkg::S_DONE : mam_pkg::S_RED_A;
        end
      end
      mam_pkg::S_RED_A: begin
        if (m_done) state_nxt = mam_pkg::S_RED_B;
      end
      mam_pkg::S_RED_B: begin
        if (m_done) state_nxt = mam_pkg::S_ARITH;
      end
      mam_pkg::S_ARITH: begin
        unique case (cmd_r)
          mam_pkg::CMD_ADD, mam_pkg::CMD_SUB: state_nxt = mam_pkg::S_CORR;
          mam_pkg::CMD_MUL: state_nxt = mam_pkg::S_MUL_FIN;
          mam_pkg::CMD_DIV: begin
            state_nxt = (b_r == '0) ? mam_pkg::S_DONE : mam_pkg::S_POW_CHK;
          end
          mam_pkg::CMD_POW: state_nxt = mam_pkg::S_POW_CHK;
          default:          state_nxt = mam_pkg::S_DONE;
        endcase
      end
      mam_pkg::S_CORR: state_nxt = mam_pkg::S_DONE;
      mam_pkg::S_POW_CHK: begin
        priority if (e_r == '0) begin
          state_nxt = (cmd_r == mam_pkg::CMD_DIV) ? mam_pkg::S_MUL_FIN : mam_pkg::S_DONE;
        end else if (e_r[0]) begin
          state_nxt = mam_pkg::S_POW_ACC;
        end else begin
          state_nxt = mam_pkg::S_POW_SQ;
        end
      end
      mam_pkg::S_POW_ACC: begin
        // last exponent bit: no need to square again
        if (m_done) state_nxt = (e_r == MOD_BITS'(1)) ? mam_pkg::S_POW_CHK : mam_pkg::S_POW_SQ;
      end
      mam_pkg::S_POW_SQ: begin
        if (m_done) state_nxt = mam_pkg::S_POW_CHK;
      end
      mam_pkg::S_MUL_FIN: begin
        if (m_done) state_nxt = mam_pkg::S_DONE;
      end
      mam_pkg::S_DONE: begin
        if (out_load) state_nxt = mam_pkg::S_IDLE;
      end
      default: state_nxt = mam_pkg::S_IDLE;
    endcase
  end

  // outputs: multiplier request and operands
  always_comb begin
    mreq.start = mul_state && !issued_r && !m_busy && !m_done;
    mreq.wide  = 1'b0;
    mx         = sq_r;
    my         = OW'(sq_r);
    unique case (state_r)
      mam_pkg::S_RED_A: begin
        mreq.wide = 1'b1;
        mx        = MOD_BITS'(1);
        my        = a_raw_r;
      end
      mam_pkg::S_RED_B: begin
        mreq.wide = 1'b1;
        mx        = MOD_BITS'(1);
        my        = b_raw_r;
      end
      mam_pkg::S_POW_ACC: begin
        mx = sq_r;
        my = OW'(acc_r);
      end
      mam_pkg::S_MUL_FIN: begin
        mx = a_r;
        my = (cmd_r == mam_pkg::CMD_DIV) ? OW'(acc_r) : OW'(b_r);
      end
      default: begin
        mx = sq_r;
        my = OW'(sq_r);
      end
    endcase
  end

  assign in_tready = (state_r == mam_pkg::S_IDLE);

  mam_mulmod #(
    .MOD_BITS(MOD_BITS)
  ) u_mulmod (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (mreq),
    .m      (mod_r),
    .x      (mx),
    .y      (my),
    .busy   (m_busy),
    .done   (m_done),
    .result (m_res)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mam_pkg::S_IDLE;
      mod_r       <= mam_pkg::MOD_RESET[MOD_BITS-1:0];
      out_valid_r <= 1'b0;
      issued_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) mod_r <= cfg_wdata;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (m_done) begin
        issued_r <= 1'b0;
      end else if (mreq.start) begin
        issued_r <= 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (out_load) out_data_r <= res_r;
    unique case (state_r)
      mam_pkg::S_IDLE: begin
        if (accept) begin
          cmd_r   <= in_tdata[CW-1:0];
          a_raw_r <= in_tdata[CW+OW-1:CW];
          b_raw_r <= in_tdata[CW+2*OW-1:CW+OW];
          res_r   <= '0;
        end
      end
      mam_pkg::S_RED_A: if (m_done) a_r <= m_res;
      mam_pkg::S_RED_B: if (m_done) b_r <= m_res;
      mam_pkg::S_ARITH: begin
        res_r <= '0;
        acc_r <= MOD_BITS'(1);
        if (cmd_r == mam_pkg::CMD_SUB) begin
          t_r <= {1'b0, a_r} - {1'b0, b_r};
        end else begin
          t_r <= {1'b0, a_r} + {1'b0, b_r};
        end
        if (cmd_r == mam_pkg::CMD_DIV) begin
          sq_r <= b_r;
          e_r  <= mod_r - MOD_BITS'(2);
        end else begin
          sq_r <= a_r;
          e_r  <= b_r;
        end
      end
      mam_pkg::S_CORR: begin
        if (cmd_r == mam_pkg::CMD_SUB) begin
          res_r <= t_r[MOD_BITS] ? corr_sum[MOD_BITS-1:0] : t_r[MOD_BITS-1:0];
        end else begin
          res_r <= corr_diff[MOD_BITS+1] ? t_r[MOD_BITS-1:0] : corr_diff[MOD_BITS-1:0];
        end
      end
      mam_pkg::S_POW_CHK: res_r <= acc_r;
      mam_pkg::S_POW_ACC: begin
        if (m_done) begin
          acc_r <= m_res;
          if (e_r == MOD_BITS'(1)) e_r <= '0;
        end
      end
      mam_pkg::S_POW_SQ: begin
        if (m_done) begin
          sq_r <= m_res;
          e_r  <= e_r >> 1;
        end
      end
      mam_pkg::S_MUL_FIN: if (m_done) res_r <= m_res;
      default: begin
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'(out_data_r);

endmodule
